/* design/sha1_message_digest_defines.svh */
// ----------------------------------------------------------------------------
// SHA-1 message digest assertion macros
// Immediate-implication and next-cycle-implication property wrappers,
// clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// same-cycle implication
`define SHA1MD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sha1md_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Item and digest types, queue sizing and SHA-1 constants.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;
  } digest_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic      valid;
    msg_item_t item;
  } q_head_t;

  // queue depth, power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

/* design/sha1md_front.sv */
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts items, drops those that carry neither a byte nor an end mark,
// and queues the rest for the compression back end.
// ----------------------------------------------------------------------------
module sha1md_front
  import sha1md_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  msg_item_t item,
  output q_head_t   head,
  input  logic      pop
);

  msg_item_t         q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;

  assign item_stall = (count == QCNT_W'(QDEPTH));
  assign push       = item_valid && !item_stall && (item.byte_present || item.last_byte);

  assign head.valid = (count != '0);
  assign head.item  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

/* design/sha1md_core.sv */
// ----------------------------------------------------------------------------
// SHA-1 back end
// Packs bytes into the schedule window, runs one round per cycle, 80 rounds
// per block, appends padding and length, registers the digest.
// ----------------------------------------------------------------------------
`include "sha1_message_digest_defines.svh"

module sha1md_core
  import sha1md_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  q_head_t head,
  output logic    pop,
  output logic    digest_valid,
  input  logic    digest_stall,
  output digest_t digest
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [5:0] POS_LAST   = 6'd63;
  localparam logic [5:0] POS_LEN    = 6'd56;

  logic [2:0]  state;
  logic [5:0]  pos;
  logic [60:0] count;
  logic [23:0] acc;
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [31:0] chain [5];
  logic [6:0]  round;
  logic        mark;
  logic        len_phase;
  logic        pad_done;
  logic [63:0] len;

  logic        ins_en;
  logic [7:0]  ins_byte;
  logic        pad_len_sel;
  logic [60:0] count_after;
  logic        w_shift;
  logic [31:0] w_in;
  logic [31:0] sched_x;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;
  logic        emit_go;

  assign pop         = (state == S_IDLE) && head.valid;
  assign count_after = head.item.byte_present ? count + 61'd1 : count;
  assign pad_len_sel = !mark && (len_phase || (pos == POS_LEN));
  assign emit_go     = (state == S_EMIT) && (!digest_valid || !digest_stall);

  always_comb begin
    ins_en   = 1'b0;
    ins_byte = head.item.data_byte;
    if (pop && head.item.byte_present) begin
      ins_en = 1'b1;
    end else if (state == S_PAD) begin
      ins_en = 1'b1;
      if (mark) begin
        ins_byte = PAD_MARK;
      end else if (pad_len_sel) begin
        ins_byte = len[63:56];
      end else begin
        ins_byte = 8'h00;
      end
    end
  end

  assign sched_x = w[13] ^ w[8] ^ w[2] ^ w[0];

  always_comb begin
    w_shift = 1'b0;
    w_in    = {sched_x[30:0], sched_x[31]};
    if (state == S_ROUND) begin
      w_shift = 1'b1;
    end else if (ins_en && (pos[1:0] == 2'd3)) begin
      w_shift = 1'b1;
      w_in    = {acc, ins_byte};
    end
  end

  always_comb begin
    if (round <= 7'd19) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round <= 7'd39) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round <= 7'd59) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + w[0];

  // byte packing, schedule window and working variables
  always_ff @(posedge clk) begin
    if (ins_en) begin
      acc <= {acc[15:0], ins_byte};
    end
    if (w_shift) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_in;
    end
    if (ins_en && (pos == POS_LAST)) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (state == S_ROUND) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pos          <= '0;
      count        <= '0;
      round        <= '0;
      mark         <= 1'b0;
      len_phase    <= 1'b0;
      pad_done     <= 1'b0;
      len          <= '0;
      digest_valid <= 1'b0;
      chain[0]     <= H0_INIT;
      chain[1]     <= H1_INIT;
      chain[2]     <= H2_INIT;
      chain[3]     <= H3_INIT;
      chain[4]     <= H4_INIT;
    end else begin
      if (digest_valid && !digest_stall && !emit_go) begin
        digest_valid <= 1'b0;
      end
      if (ins_en) begin
        pos <= pos + 6'd1;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            count <= count_after;
            if (head.item.last_byte) begin
              mark <= 1'b1;
              len  <= {count_after, 3'b000};
            end
            if (head.item.byte_present && (pos == POS_LAST)) begin
              state <= S_ROUND;
              round <= '0;
            end else if (head.item.last_byte) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (mark) begin
            mark <= 1'b0;
          end else if (pad_len_sel) begin
            len_phase <= 1'b1;
            len       <= {len[55:0], 8'h00};
          end
          if (pos == POS_LAST) begin
            state <= S_ROUND;
            round <= '0;
            if (pad_len_sel) begin
              pad_done <= 1'b1;
            end
          end
        end
        S_ROUND: begin
          round <= round + 7'd1;
          if (round == ROUND_LAST) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          // mark or length not yet shifted out: a further padding block follows
          if (pad_done) begin
            state <= S_EMIT;
          end else if (mark || len_phase || (len != '0)) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            digest_valid <= 1'b1;
            chain[0]     <= H0_INIT;
            chain[1]     <= H1_INIT;
            chain[2]     <= H2_INIT;
            chain[3]     <= H3_INIT;
            chain[4]     <= H4_INIT;
            count        <= '0;
            len_phase    <= 1'b0;
            pad_done     <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      digest.digest_word0 <= chain[0];
      digest.digest_word1 <= chain[1];
      digest.digest_word2 <= chain[2];
      digest.digest_word3 <= chain[3];
      digest.digest_word4 <= chain[4];
    end
  end

  `SHA1MD_ASSERT_NEXT(a_round_end, (state == S_ROUND) && (round == ROUND_LAST), state == S_ADD, "round count did not end in chain add")
  `SHA1MD_ASSERT_SAME(a_block_start, ($past(state) != S_ROUND) && (state == S_ROUND), pos == '0, "compression started with partial block")
  `SHA1MD_ASSERT_NEXT(a_emit, emit_go, digest_valid && (state == S_IDLE) && (count == '0), "digest load did not restart message")

endmodule

/* design/sha1_message_digest.sv */
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Byte-per-item SHA-1 hasher: queued front end, round-per-cycle back end.
// ----------------------------------------------------------------------------
//   channel   valid          stall          payload
//   input     item_valid     item_stall     item   (msg_item_t)
//   output    digest_valid   digest_stall   digest (digest_t)
//
// The back end takes a byte item only while idle; each completed 64-byte
// block runs 80 rounds of the shared round unit plus the chain add.
// The last item adds 9 to 72 padding bytes, then one or two compressions
// and a load of the digest register.
// Synchronous reset restores the initial chain words and empties the queue.
// The four-entry queue stalls input only when full; a stalled digest holds
// the back end in its final state until taken.
module sha1_message_digest
  import sha1md_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  msg_item_t item,
  output logic      digest_valid,
  input  logic      digest_stall,
  output digest_t   digest
);

  q_head_t head;
  logic    pop;

  sha1md_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .head       (head),
    .pop        (pop)
  );

  sha1md_core u_core (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

endmodule

/* tb/sv/tb_sha1_message_digest.sv */
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Streams messages one byte per item into the hasher, checks each digest
// against an in-bench SHA-1 model, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest
  import sha1md_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAYLOAD_TARGET = 1350;
  localparam int MIN_MESSAGES   = 24;
  localparam int DRAIN_CYCLES   = 400;
  localparam int IDLE_LIMIT     = 4000;

  logic      clk;
  logic      rst          = 1'b1;
  logic      item_valid   = 1'b0;
  logic      item_stall;
  msg_item_t item         = '0;
  logic      digest_valid;
  logic      digest_stall = 1'b0;
  digest_t   digest;

  sha1_message_digest DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

  // model state
  logic [31:0] hash_state [5];
  logic [7:0]  blk_bytes [64];
  logic [60:0] byte_total;

  msg_item_t pending_items [$];
  digest_t   expected_digests [$];

  int  items_queued   = 0;
  int  items_taken    = 0;
  int  payload_items  = 0;
  int  digests_seen   = 0;
  int  mismatch_count = 0;
  int  gap_left       = 0;
  int  stall_left     = 0;
  int  idle_cycles    = 0;
  bit  in_acc         = 1'b0;
  bit  calm           = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void sha1_restart();
    hash_state[0] = H0_INIT;
    hash_state[1] = H1_INIT;
    hash_state[2] = H2_INIT;
    hash_state[3] = H3_INIT;
    hash_state[4] = H4_INIT;
    byte_total    = '0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    int r;
    for (r = 0; r < 16; r++)
      w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (r = 0; r < 80; r++) begin
      if (r >= 16) begin
        t = w[(r-3) & 15] ^ w[(r-8) & 15] ^ w[(r-14) & 15] ^ w[r & 15];
        w[r & 15] = {t[30:0], t[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r & 15];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  // returns 1 when the item closes a message; dg then holds its digest
  function automatic bit sha1_absorb(input msg_item_t it, output digest_t dg);
    int pos, j;
    logic [63:0] bit_len;
    dg = '0;
    if (it.byte_present) begin
      pos = int'(byte_total[5:0]);
      blk_bytes[pos] = it.data_byte;
      byte_total = byte_total + 61'd1;
      if (pos == 63) sha1_compress();
    end
    if (!it.last_byte) return 1'b0;
    pos = int'(byte_total[5:0]);
    blk_bytes[pos] = PAD_MARK;
    pos++;
    if (pos > 56) begin
      for (j = pos; j < 64; j++) blk_bytes[j] = 8'h00;
      sha1_compress();
      pos = 0;
    end
    for (j = pos; j < 56; j++) blk_bytes[j] = 8'h00;
    bit_len = {byte_total, 3'b000};
    for (j = 0; j < 8; j++) blk_bytes[56+j] = bit_len[8*(7-j) +: 8];
    sha1_compress();
    dg = {hash_state[0], hash_state[1], hash_state[2], hash_state[3], hash_state[4]};
    sha1_restart();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_digest(input digest_t got);
    digest_t want;
    logic [159:0] g, w;
    int i;
    if (expected_digests.size() == 0) begin
      report_mismatch($sformatf("unexpected digest %h", got));
      return;
    end
    want = expected_digests.pop_front();
    g = got;
    w = want;
    for (i = 0; i < 5; i++)
      if (g[159-32*i -: 32] !== w[159-32*i -: 32])
        report_mismatch($sformatf("digest %0d word%0d got %h want %h",
                                  digests_seen, i, g[159-32*i -: 32], w[159-32*i -: 32]));
    digests_seen++;
  endtask

  function automatic int pick_idle();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // monitor and model update
  always @(posedge clk) begin : monitor
    digest_t want;
    if (rst) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= item_valid && !item_stall;
      if (digest_valid && !digest_stall) check_digest(digest);
      if (item_valid && !item_stall) begin
        items_taken++;
        if (sha1_absorb(item, want)) expected_digests.push_back(want);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (digest_valid && !digest_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // item driver
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || in_acc) begin
      if (gap_left > 0) begin
        item_valid <= 1'b0;
        gap_left--;
      end else if (pending_items.size() != 0) begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
        gap_left = pick_idle();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // digest receiver back-pressure
  always @(negedge clk) begin : receiver
    int n;
    if (rst) begin
      digest_stall <= 1'b0;
    end else if (stall_left > 0) begin
      digest_stall <= 1'b1;
      stall_left--;
    end else begin
      n = pick_idle();
      digest_stall <= (n > 0);
      stall_left = (n > 0) ? n - 1 : 0;
    end
  end

  task automatic push_fields(input logic [7:0] b, input bit present, input bit last);
    msg_item_t it;
    it.data_byte    = b;
    it.byte_present = present;
    it.last_byte    = last;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_message(input int len);
    int i;
    bit empty_tail;
    empty_tail = (len == 0) || ($urandom_range(0, 4) == 0);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0)
        push_fields(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_fields(8'($urandom_range(0, 255)), 1'b1, !empty_tail && (i == len - 1));
      payload_items++;
    end
    if (empty_tail) begin
      push_fields(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      payload_items++;
    end
  endtask

  function automatic int pick_length();
    int r;
    int edge_len [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 20);
    if (r < 85) return edge_len[$urandom_range(0, 9)];
    return $urandom_range(21, 200);
  endfunction

  task automatic wait_for_quiet();
    while (items_taken != items_queued || expected_digests.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    int m;
    int edge_first [8] = '{55, 56, 63, 64, 119, 120, 0, 128};
    sha1_restart();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty message, lone bytes, ignored empty items, "abc"
    push_fields(8'h00, 1'b0, 1'b1);
    push_fields(8'hFF, 1'b0, 1'b0);
    push_fields(8'h00, 1'b1, 1'b1);
    push_fields(8'hFF, 1'b1, 1'b0);
    push_fields(8'hA5, 1'b1, 1'b0);
    push_fields(8'h5A, 1'b0, 1'b0);
    push_fields(8'hFF, 1'b0, 1'b1);
    push_fields(8'h61, 1'b1, 1'b0);
    push_fields(8'h62, 1'b1, 1'b0);
    push_fields(8'h63, 1'b1, 1'b1);
    push_fields(8'h80, 1'b1, 1'b1);
    push_fields(8'h7F, 1'b1, 1'b1);
    push_fields(8'hFF, 1'b1, 1'b1);
    push_fields(8'h00, 1'b0, 1'b1);
    push_fields(8'hAA, 1'b0, 1'b1);
    wait_for_quiet();

    m = 0;
    while (payload_items < PAYLOAD_TARGET || m < MIN_MESSAGES) begin
      calm = (m % 12) < 3;
      if (m == 20) wait_for_quiet();
      queue_message(m < 8 ? edge_first[m] : pick_length());
      m++;
      while (pending_items.size() > 8) @(posedge clk);
    end

    wait_for_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/sha1md_pkg.sv
design/sha1md_front.sv
design/sha1md_core.sv
design/sha1_message_digest.sv
tb/sv/tb_sha1_message_digest.sv
